// ===== design/hs_pkg.sv =====
// Package for the heap sorter: beat payload types, datapath operation codes
// and the status group returned by the datapath. No dependencies.
package hs_pkg;

	// Key width is fixed by the interface.
	localparam int KEY_W = 16;

	// Input beat payload.
	typedef struct packed {
		logic signed [KEY_W-1:0] key_value;
		logic                    last_key;
	} hs_in_t;

	// Output beat payload.
	typedef struct packed {
		logic signed [KEY_W-1:0] sorted_key;
		logic                    last_out;
		logic                    overflowed;
	} hs_out_t;

	// Operation issued by the controller to the datapath each cycle.
	typedef enum logic [4:0] {
		OP_NONE        = 5'd0,
		OP_LOAD        = 5'd1,
		OP_SORT_INIT   = 5'd2,
		OP_EXT_INIT    = 5'd3,
		OP_BLD_STEP    = 5'd4,
		OP_NODE_CAP    = 5'd5,
		OP_RD_LC       = 5'd6,
		OP_LC_CAP      = 5'd7,
		OP_RC_CAP      = 5'd8,
		OP_CMP         = 5'd9,
		OP_SWAP        = 5'd10,
		OP_EXT_RD_HI   = 5'd11,
		OP_EXT_RD_ROOT = 5'd12,
		OP_EXT_WR_HI   = 5'd13,
		OP_EXT_WR_ROOT = 5'd14,
		OP_OUT_INIT    = 5'd15,
		OP_OUT_RD      = 5'd16,
		OP_OUT_LD      = 5'd17,
		OP_OUT_NEXT    = 5'd18
	} hs_op_t;

	// Status flags returned by the datapath.
	typedef struct packed {
		logic in_last;
		logic k_zero;
		logic k_le1;
		logic lc_ok;
		logic rc_ok;
		logic big_is_node;
		logic out_last;
	} hs_sts_t;

endpackage

// ===== design/hs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/hs_dp.sv =====
// Heap sorter datapath: key store, counters, sift-down registers and the
// output register. Depends on hs_pkg and hs_ram.
module hs_dp import hs_pkg::*; #(
	parameter int MAX_KEYS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  hs_op_t  op,
	output hs_sts_t sts,
	input  hs_in_t  in_data,
	output logic    out_valid,
	output hs_out_t out_data
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int XW = AW + 2;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          out_valid_q;
	hs_out_t       out_q;
	logic [CW-1:0] hsize_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] node_q;
	logic [AW-1:0] big_q;
	logic          has_r_q;
	logic signed [KEY_W-1:0] nv_q;
	logic signed [KEY_W-1:0] lv_q;
	logic signed [KEY_W-1:0] rv_q;

	logic [XW-1:0] lc_x;
	logic [XW-1:0] rc_x;
	logic [XW-1:0] hsize_x;
	logic [CW-1:0] km1;
	logic          room;
	logic          take_l;
	logic          take_r;
	logic signed [KEY_W-1:0] bv;
	logic signed [KEY_W-1:0] wv;
	logic [AW-1:0] big_idx;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [KEY_W-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [KEY_W-1:0] rdata;

	hs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Child indices of the current node and the heap compare.
	always_comb begin
		lc_x    = {1'b0, node_q, 1'b1};
		rc_x    = {1'b0, node_q, 1'b0} + XW'(2);
		hsize_x = XW'(hsize_q);
		km1     = k_q - CW'(1);
		room    = cnt_q < CW'(MAX_KEYS);
		take_l  = lv_q > nv_q;
		bv      = take_l ? lv_q : nv_q;
		take_r  = has_r_q && (rv_q > bv);
		wv      = take_r ? rv_q : lv_q;
		big_idx = take_r ? rc_x[AW-1:0] : lc_x[AW-1:0];
	end

	// Status back to the controller.
	always_comb begin
		sts.in_last     = in_data.last_key;
		sts.k_zero      = k_q == '0;
		sts.k_le1       = k_q <= CW'(1);
		sts.lc_ok       = lc_x < hsize_x;
		sts.rc_ok       = rc_x < hsize_x;
		sts.big_is_node = !take_l && !take_r;
		sts.out_last    = k_q == (cnt_q - CW'(1));
	end

	// Store port control per operation.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = nv_q;
		raddr = '0;
		unique case (op)
			OP_LOAD: begin
				we    = room;
				waddr = cnt_q[AW-1:0];
				wdata = in_data.key_value;
			end
			OP_BLD_STEP:  raddr = km1[AW-1:0];
			OP_RD_LC:     raddr = lc_x[AW-1:0];
			OP_LC_CAP:    raddr = rc_x[AW-1:0];
			OP_CMP: begin
				we    = 1'b1;
				waddr = node_q;
				wdata = wv;
			end
			OP_SWAP: begin
				we    = 1'b1;
				waddr = big_q;
			end
			OP_EXT_RD_HI: raddr = km1[AW-1:0];
			OP_EXT_WR_HI: begin
				we    = 1'b1;
				waddr = km1[AW-1:0];
				wdata = rdata;
			end
			OP_EXT_WR_ROOT: begin
				we    = 1'b1;
			end
			OP_OUT_RD:    raddr = k_q[AW-1:0];
			default: begin
			end
		endcase
	end

	// Set count, overflow flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_LOAD) begin
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (op == OP_OUT_LD) begin
				out_valid_q <= 1'b1;
			end
			if (op == OP_OUT_NEXT) begin
				out_valid_q <= 1'b0;
				if (sts.out_last) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// Sort registers and the output payload.
	always_ff @(posedge clk) begin
		case (op)
			OP_SORT_INIT: begin
				hsize_q <= cnt_q;
				k_q     <= cnt_q >> 1;
			end
			OP_EXT_INIT:  k_q <= hsize_q;
			OP_BLD_STEP: begin
				node_q <= km1[AW-1:0];
				k_q    <= km1;
			end
			OP_NODE_CAP:  nv_q <= rdata;
			OP_LC_CAP: begin
				lv_q    <= rdata;
				has_r_q <= sts.rc_ok;
			end
			OP_RC_CAP:    rv_q <= rdata;
			OP_CMP:       big_q <= big_idx;
			OP_SWAP:      node_q <= big_q;
			OP_EXT_RD_ROOT: nv_q <= rdata;
			OP_EXT_WR_ROOT: begin
				node_q  <= '0;
				hsize_q <= km1;
				k_q     <= km1;
			end
			OP_OUT_INIT:  k_q <= '0;
			OP_OUT_LD: begin
				out_q.sorted_key <= rdata;
				out_q.last_out   <= sts.out_last;
				out_q.overflowed <= ovf_q;
			end
			OP_OUT_NEXT: begin
				if (!sts.out_last) begin
					k_q <= k_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/hs_ctrl.sv =====
// Heap sorter controller: sequences load, heap build, extraction and output.
// Depends on hs_pkg.
module hs_ctrl import hs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    out_ready,
	input  hs_sts_t sts,
	output hs_op_t  op
);

	typedef enum logic [15:0] {
		ST_IDLE      = 16'h0001,
		ST_SORT_INIT = 16'h0002,
		ST_BLD_CHECK = 16'h0004,
		ST_SD_NODE   = 16'h0008,
		ST_SD_LC     = 16'h0010,
		ST_SD_LCW    = 16'h0020,
		ST_SD_RCW    = 16'h0040,
		ST_SD_CMP    = 16'h0080,
		ST_SD_SWAP   = 16'h0100,
		ST_EXT_CHECK = 16'h0200,
		ST_EXT_RA    = 16'h0400,
		ST_EXT_RB    = 16'h0800,
		ST_EXT_W0    = 16'h1000,
		ST_OUT_RD    = 16'h2000,
		ST_OUT_LD    = 16'h4000,
		ST_OUT_WAIT  = 16'h8000
	} hs_state_t;

	hs_state_t state_q;
	hs_state_t state_d;
	hs_state_t sift_ret;
	logic      extract_q;

	// A finished sift-down returns to the loop that started it.
	assign sift_ret = extract_q ? ST_EXT_CHECK : ST_BLD_CHECK;
	assign in_ready = state_q == ST_IDLE;

	// Next state and datapath operation.
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op = OP_LOAD;
					if (sts.in_last) begin
						state_d = ST_SORT_INIT;
					end
				end
			end
			ST_SORT_INIT: begin
				op      = OP_SORT_INIT;
				state_d = ST_BLD_CHECK;
			end
			ST_BLD_CHECK: begin
				if (sts.k_zero) begin
					op      = OP_EXT_INIT;
					state_d = ST_EXT_CHECK;
				end else begin
					op      = OP_BLD_STEP;
					state_d = ST_SD_NODE;
				end
			end
			ST_SD_NODE: begin
				op      = OP_NODE_CAP;
				state_d = ST_SD_LC;
			end
			ST_SD_LC: begin
				if (sts.lc_ok) begin
					op      = OP_RD_LC;
					state_d = ST_SD_LCW;
				end else begin
					state_d = sift_ret;
				end
			end
			ST_SD_LCW: begin
				op      = OP_LC_CAP;
				state_d = sts.rc_ok ? ST_SD_RCW : ST_SD_CMP;
			end
			ST_SD_RCW: begin
				op      = OP_RC_CAP;
				state_d = ST_SD_CMP;
			end
			ST_SD_CMP: begin
				if (sts.big_is_node) begin
					state_d = sift_ret;
				end else begin
					op      = OP_CMP;
					state_d = ST_SD_SWAP;
				end
			end
			ST_SD_SWAP: begin
				op      = OP_SWAP;
				state_d = ST_SD_LC;
			end
			ST_EXT_CHECK: begin
				if (sts.k_le1) begin
					op      = OP_OUT_INIT;
					state_d = ST_OUT_RD;
				end else begin
					op      = OP_EXT_RD_HI;
					state_d = ST_EXT_RA;
				end
			end
			ST_EXT_RA: begin
				op      = OP_EXT_RD_ROOT;
				state_d = ST_EXT_RB;
			end
			ST_EXT_RB: begin
				op      = OP_EXT_WR_HI;
				state_d = ST_EXT_W0;
			end
			ST_EXT_W0: begin
				op      = OP_EXT_WR_ROOT;
				state_d = ST_SD_LC;
			end
			ST_OUT_RD: begin
				op      = OP_OUT_RD;
				state_d = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				op      = OP_OUT_LD;
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (out_ready) begin
					op      = OP_OUT_NEXT;
					state_d = sts.out_last ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register and the build/extract phase flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			extract_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_SORT_INIT) begin
				extract_q <= 1'b0;
			end else if (op == OP_EXT_INIT) begin
				extract_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/heap_sorter_unit.sv =====
// Heap sorter top level: ties the controller to the datapath and its key store.
// Depends on hs_pkg, hs_ctrl and hs_dp.
// Input: a key without the last mark is only taken in. A last-marked key
// starts an in-place heap sort in a store with one read port and one write port
// (one read, one write per cycle): sift-downs build the heap, each extraction
// sifts the new root down, then the sorted keys go out, subject to any output stall.
// Reset clears the controller, set count, overflow flag and output valid; the
// key store is not cleared. Input is taken only while no set is being sorted.
module heap_sorter_unit import hs_pkg::*; #(
	parameter int MAX_KEYS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  hs_in_t  in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output hs_out_t out_data
);

	hs_op_t  op;
	hs_sts_t sts;

	hs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.sts       (sts),
		.op        (op)
	);

	hs_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// Loading and emitting never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a sorted beat is pending");

	// The final sorted beat reopens the input.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last_out) |=> in_ready)
		else $error("input not reopened after the final sorted beat");

	// A last-marked beat closes the input for sorting.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.last_key) |=> !in_ready)
		else $error("input still open after the last key of a set");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for heap_sorter_unit: sends sets of signed keys and
// checks that each set comes back in ascending order with the right flags.
// Depends on hs_pkg and heap_sorter_unit.
module tb_top;
	import hs_pkg::*;

	localparam int CAPACITY       = 64;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int RAND_ITEMS     = 500;
	localparam int CALM_AFTER     = 420;
	localparam int SECOND_HOLD_AT = 250;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 20;

	// Holds the keys of the open set in ascending order and the sorted beats
	// still owed by the block.
	class sort_scoreboard;
		int      capacity;
		int      set_keys[$];
		bit      set_dropped;
		hs_out_t sorted_due[$];
		int      errors;

		function new(input int cap);
			capacity    = cap;
			set_dropped = 1'b0;
			errors      = 0;
		endfunction

		function int pending();
			return sorted_due.size();
		endfunction

		task report(input string msg);
			if (errors < 100) begin
				$display("mismatch: %s", msg);
			end
			errors++;
		endtask

		// Take one accepted input beat; a last-marked beat closes the set.
		function void note_key(input hs_in_t beat);
			int      key;
			int      pos;
			int      n;
			hs_out_t item;
			key = $signed(beat.key_value);
			if (set_keys.size() < capacity) begin
				pos = 0;
				while (pos < set_keys.size() && set_keys[pos] <= key) pos++;
				set_keys.insert(pos, key);
			end else begin
				set_dropped = 1'b1;
			end
			if (beat.last_key) begin
				n = set_keys.size();
				for (int i = 0; i < n; i++) begin
					item.sorted_key = set_keys[i][KEY_W-1:0];
					item.last_out   = (i == n - 1);
					item.overflowed = set_dropped;
					sorted_due.push_back(item);
				end
				set_keys.delete();
				set_dropped = 1'b0;
			end
		endfunction

		// Compare one accepted output beat with the oldest expected one.
		task check_result(input hs_out_t got);
			hs_out_t want;
			if (sorted_due.size() == 0) begin
				report($sformatf("unexpected beat, key %0d", got.sorted_key));
			end else begin
				want = sorted_due.pop_front();
				if (got.sorted_key !== want.sorted_key) begin
					report($sformatf("sorted_key got %0d want %0d",
						got.sorted_key, want.sorted_key));
				end
				if (got.last_out !== want.last_out) begin
					report($sformatf("last_out got %b want %b", got.last_out, want.last_out));
				end
				if (got.overflowed !== want.overflowed) begin
					report($sformatf("overflowed got %b want %b",
						got.overflowed, want.overflowed));
				end
			end
		endtask
	endclass

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	logic    in_ready;
	hs_in_t  in_data   = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	hs_out_t out_data;

	sort_scoreboard sb = new(CAPACITY);

	int hold_asked  = 0;
	int hold_done   = 0;
	int hold_left   = 0;
	int burst_left  = 0;
	int cycle_count = 0;
	bit calm        = 1'b0;

	heap_sorter_unit #(.MAX_KEYS(CAPACITY)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("heap_sorter_unit regression: fail");
			$finish;
		end
	end

	// Output side: check each accepted beat, then pick the next ready level.
	// A requested long hold starts once a beat is waiting.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				sb.check_result(out_data);
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_asked != hold_done && out_valid) begin
				hold_done++;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (burst_left != 0) begin
				burst_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(1, 10) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one key and wait until the block takes the beat.
	task automatic send_key(input logic [KEY_W-1:0] key, input logic is_last);
		hs_in_t beat;
		beat.key_value = key;
		beat.last_key  = is_last;
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_key(beat);
	endtask

	task automatic idle_in(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every owed beat has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Keys lean toward the extremes and a narrow band that repeats values.
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h8000;
		if (r == 1) return 16'h7fff;
		if (r <= 3) return KEY_W'($urandom_range(0, 7) - 4);
		return KEY_W'($urandom);
	endfunction

	// Mostly short sets; a few fill the store or run past it.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(1, 8);
		if (r < 80) return $urandom_range(9, 31);
		if (r < 92) return $urandom_range(32, CAPACITY - 1);
		if (r < 96) return CAPACITY;
		return $urandom_range(CAPACITY + 1, CAPACITY + 4);
	endfunction

	// Input side: reset, directed sets, then random sets.
	initial begin
		int rand_sent;
		int set_idx;
		int set_len;
		bit second_hold;
		rand_sent   = 0;
		set_idx     = 0;
		second_hold = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A set of one key, the most negative value.
		send_key(16'h8000, 1'b1);
		// Extremes and alternating bit patterns.
		send_key(16'h7fff, 1'b0);
		send_key(16'h8000, 1'b0);
		send_key(16'h0000, 1'b0);
		send_key(16'hffff, 1'b0);
		send_key(16'h0001, 1'b0);
		send_key(16'h5555, 1'b0);
		send_key(16'haaaa, 1'b1);
		// Repeated keys.
		send_key(16'd5, 1'b0);
		send_key(16'd5, 1'b0);
		send_key(16'd5, 1'b0);
		send_key(16'hfffd, 1'b0);
		send_key(16'd5, 1'b1);
		// Keys already in descending order.
		send_key(16'd40, 1'b0);
		send_key(16'd30, 1'b0);
		send_key(16'd20, 1'b0);
		send_key(16'd10, 1'b1);
		// A set of one key, the most positive value.
		send_key(16'h7fff, 1'b1);
		wait_drained();

		// The first random set meets a long output hold, so the sets behind it stall.
		hold_asked++;
		while (rand_sent < RAND_ITEMS) begin
			// One set runs past the store and one fills it exactly.
			if (set_idx == 3) begin
				set_len = CAPACITY + 2;
			end else if (set_idx == 6) begin
				set_len = CAPACITY;
			end else begin
				set_len = pick_len();
			end
			for (int i = 0; i < set_len; i++) begin
				if (!calm && $urandom_range(0, 3) == 0) begin
					idle_in($urandom_range(1, 10));
				end
				send_key(pick_key(), i == set_len - 1);
				rand_sent++;
				if (rand_sent >= CALM_AFTER) calm = 1'b1;
			end
			if (!second_hold && rand_sent >= SECOND_HOLD_AT) begin
				hold_asked++;
				second_hold = 1'b1;
			end else if (set_idx % 10 == 9) begin
				wait_drained();
			end
			set_idx++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("heap_sorter_unit regression: pass");
		end else begin
			$display("heap_sorter_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/hs_pkg.sv
design/hs_ram.sv
design/hs_dp.sv
design/hs_ctrl.sv
design/heap_sorter_unit.sv
test/tb_top.sv
